// ----- rtl/tsa_pkg.sv -----
// tsa_pkg: shared types, codes and helpers for the truss stiffness assembly block.
// Used by every module under rtl/ except tsa_div. No dependencies.
package tsa_pkg;

  // Store geometry
  localparam int MAX_DOF     = 64;
  localparam int STORE_DEPTH = MAX_DOF * MAX_DOF;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 48;
  localparam int CODE_W      = 7;
  localparam int NCODES      = 6;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Function codes of an input transaction
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  // Command kinds handed to the back end
  localparam logic [1:0] KD_RESP  = 2'd0;
  localparam logic [1:0] KD_CLEAR = 2'd1;
  localparam logic [1:0] KD_ADD   = 2'd2;
  localparam logic [1:0] KD_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [15:0] direction_z;
    logic [23:0]        section_area;
    logic [23:0]        elastic_modulus;
    logic [23:0]        member_length;
    logic [41:0]        end_codes;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } tsa_in_t;

  typedef struct packed {
    logic signed [47:0] entry_value;
    logic [1:0]         status;
  } tsa_out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [47:0]        num;     // a * e
    logic [33:0]        den;     // 1000 * l
    logic [41:0]        codes;
    logic [ADDR_W-1:0]  raddr;
  } tsa_cmd_t;

  typedef struct packed {
    logic init_busy;   // clearing pass after reset in progress
  } tsa_back_stat_t;

  // Row-major store address of (row, col)
  function automatic logic [ADDR_W-1:0] store_addr(input logic [CODE_W-1:0] row,
                                                   input logic [CODE_W-1:0] col);
    store_addr = ADDR_W'(row * MAX_DOF + col);
  endfunction

endpackage

// ----- rtl/truss_stiffness_assembly.sv -----
// Truss stiffness assembly (3-D direct stiffness method), top level.
// Back end steps: a clear writes every store entry; a read reads the entry and then returns it;
// a flagged or unused-function transaction returns its status at once; an add member runs the
// 64-step divider, then PAIR, MUL and ACC for each stored entry and PAIR alone per skipped pair.
// The back end takes one transaction at a time, and only while its result slot is free;
// a 2-deep command queue takes items meanwhile.
// Reset (rst_n, synchronous, active low) starts a clearing pass of all 4096 store entries
// during which in_stall is high; dof_count resets to 64.
module truss_stiffness_assembly (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsa_pkg::tsa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tsa_pkg::tsa_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);

  tsa_pkg::tsa_cmd_t       push_cmd;
  tsa_pkg::tsa_cmd_t       q_data;
  tsa_pkg::tsa_back_stat_t back_stat;
  logic                    push;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;

  tsa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .back_stat   (back_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  tsa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  tsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .back_stat (back_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tsa_front.sv -----
// tsa_front: input acceptance, config register, range/length checks, command build.
// Depends on tsa_pkg.
module tsa_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tsa_pkg::tsa_in_t        in_data,
  input  logic                    cfg_wr_en,
  input  logic [6:0]              cfg_wr_data,
  input  logic                    q_full,
  input  tsa_pkg::tsa_back_stat_t back_stat,
  output logic                    push,
  output tsa_pkg::tsa_cmd_t       cmd
);

  logic [6:0] dof_count_r;
  logic [6:0] n_use;
  logic       code_bad;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dof_count_r <= 7'd64;
    end else if (cfg_wr_en) begin
      dof_count_r <= cfg_wr_data;
    end
  end

  assign n_use    = (dof_count_r > 7'(tsa_pkg::MAX_DOF)) ? 7'(tsa_pkg::MAX_DOF) : dof_count_r;
  assign in_stall = q_full | back_stat.init_busy;
  assign push     = in_valid & ~in_stall;

  // Any nonzero code beyond size in use
  always_comb begin
    code_bad = 1'b0;
    for (int i = 0; i < tsa_pkg::NCODES; i++) begin
      if (in_data.end_codes[i*tsa_pkg::CODE_W +: tsa_pkg::CODE_W] > n_use) code_bad = 1'b1;
    end
  end

  // Classify and build command
  always_comb begin
    cmd        = '0;
    cmd.dx     = in_data.direction_x;
    cmd.dy     = in_data.direction_y;
    cmd.dz     = in_data.direction_z;
    cmd.num    = 48'(in_data.section_area) * 48'(in_data.elastic_modulus);
    cmd.den    = 34'(in_data.member_length) * 34'd1000;
    cmd.codes  = in_data.end_codes;
    cmd.raddr  = tsa_pkg::store_addr({1'b0, in_data.read_row}, {1'b0, in_data.read_col});
    cmd.kind   = tsa_pkg::KD_RESP;
    cmd.status = tsa_pkg::ST_OK;
    case (in_data.func)
      tsa_pkg::FN_CLEAR: begin
        cmd.kind = tsa_pkg::KD_CLEAR;
      end
      tsa_pkg::FN_ADD: begin
        if (code_bad) begin
          cmd.status = tsa_pkg::ST_RANGE;
        end else if (in_data.member_length == 24'd0) begin
          cmd.status = tsa_pkg::ST_ZERO_LEN;
        end else begin
          cmd.kind = tsa_pkg::KD_ADD;
        end
      end
      tsa_pkg::FN_READ: begin
        if ({1'b0, in_data.read_row} >= n_use || {1'b0, in_data.read_col} >= n_use) begin
          cmd.status = tsa_pkg::ST_RANGE;
        end else begin
          cmd.kind = tsa_pkg::KD_READ;
        end
      end
      default: begin
        cmd.kind = tsa_pkg::KD_RESP;
      end
    endcase
  end

endmodule

// ----- rtl/tsa_queue.sv -----
// tsa_queue: short command FIFO between front and back end.
// Depends on tsa_pkg.
module tsa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  tsa_pkg::tsa_cmd_t wr_data,
  input  logic              rd_en,
  output tsa_pkg::tsa_cmd_t rd_data,
  output logic              full,
  output logic              empty
);

  tsa_pkg::tsa_cmd_t               slot_r [tsa_pkg::QDEPTH];
  logic [tsa_pkg::QPTR_W-1:0]      wptr_r;
  logic [tsa_pkg::QPTR_W-1:0]      rptr_r;
  logic [tsa_pkg::QPTR_W:0]        cnt_r;

  assign full    = (cnt_r == (tsa_pkg::QPTR_W+1)'(tsa_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wptr_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("queue write while full");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd_en)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (wr_en && !rd_en) |=> !empty)
    else $error("queue empty after write");

endmodule

// ----- rtl/tsa_div.sv -----
// tsa_div: radix-2 restoring divider, 64-bit dividend by 34-bit divisor, one bit per cycle.
// Depends on nothing outside this file.
module tsa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [33:0] rem_r;
  logic [33:0] den_r;
  logic [63:0] quo_r;
  logic [34:0] trial;
  logic        qbit;
  logic [33:0] rem_nxt;

  // One quotient bit per step
  assign trial   = {rem_r, dvd_r[63]};
  assign qbit    = (trial >= {1'b0, den_r});
  assign rem_nxt = qbit ? 34'(trial - {1'b0, den_r}) : trial[33:0];

  assign done     = done_r;
  assign quotient = quo_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[62:0], qbit};
    end
  end

endmodule

// ----- rtl/tsa_back.sv -----
// tsa_back: executes queued commands: store clear, member accumulate, entry read, status-only response.
// Depends on tsa_pkg and tsa_div; holds the stiffness store memory.
module tsa_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsa_pkg::tsa_cmd_t       q_data,
  input  logic                    q_empty,
  output logic                    q_pop,
  output tsa_pkg::tsa_back_stat_t back_stat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tsa_pkg::tsa_out_t       out_data
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_RDOUT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_PAIR  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_ACC   = 3'd7;

  localparam logic signed [49:0] ENT_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] ENT_MIN = -50'sd140737488355328;
  localparam logic [63:0]        MAG_LIM = 64'd140737488355328;

  logic [2:0]                   state_r;
  logic [tsa_pkg::ADDR_W-1:0]   clr_cnt_r;
  logic                         out_valid_r;
  tsa_pkg::tsa_out_t            out_data_r;
  logic                         slot_free;
  logic                         load_out;
  tsa_pkg::tsa_out_t            load_val;

  // Member working set
  logic [41:0]                  codes_r;
  logic signed [15:0]           dx_r, dy_r, dz_r;
  logic [2:0]                   x_r, y_r;
  logic                         sat_r;
  logic [30:0]                  p_r;
  logic                         neg_r;
  logic [tsa_pkg::ADDR_W-1:0]   addr_r;
  logic [62:0]                  phi_r, plo_r;

  // Store memory
  logic [tsa_pkg::ENTRY_W-1:0]  mem [tsa_pkg::STORE_DEPTH];
  logic                         we, re;
  logic [tsa_pkg::ADDR_W-1:0]   waddr, raddr;
  logic [tsa_pkg::ENTRY_W-1:0]  wdata;
  logic [tsa_pkg::ENTRY_W-1:0]  rdata_r;

  // Divider
  logic                         div_start;
  logic                         div_done;
  logic [63:0]                  f_q;

  logic [6:0]                   cx, cy;
  logic                         last_pair;
  logic signed [15:0]           da, db;
  logic signed [31:0]           prod;
  logic [63:0]                  mag;
  logic [47:0]                  mag_lim;
  logic                         mag_sat;
  logic signed [49:0]           term;
  logic signed [49:0]           sum;
  logic signed [49:0]           sum_cl;
  logic                         sum_sat;

  tsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({q_data.num, 16'd0}),
    .divisor  (q_data.den),
    .done     (div_done),
    .quotient (f_q)
  );

  assign slot_free = ~out_valid_r | ~out_stall;
  assign q_pop     = (state_r == S_IDLE) & ~q_empty & slot_free;
  assign div_start = q_pop & (q_data.kind == tsa_pkg::KD_ADD);
  assign back_stat.init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Code of the current row/column and direction cosines
  assign cx        = codes_r[x_r*7 +: 7];
  assign cy        = codes_r[y_r*7 +: 7];
  assign last_pair = (x_r == 3'd5) && (y_r == 3'd5);

  always_comb begin
    case (x_r)
      3'd0, 3'd3: da = dx_r;
      3'd1, 3'd4: da = dy_r;
      default:    da = dz_r;
    endcase
    case (y_r)
      3'd0, 3'd3: db = dx_r;
      3'd1, 3'd4: db = dy_r;
      default:    db = dz_r;
    endcase
  end
  assign prod = da * db;

  // Term magnitude, clamp and accumulate
  assign mag     = {phi_r[59:0], 4'd0} + 64'(plo_r[62:28]);
  assign mag_sat = (mag > MAG_LIM);
  assign mag_lim = mag_sat ? MAG_LIM[47:0] : mag[47:0];
  assign term    = neg_r ? -$signed({2'b00, mag_lim}) : $signed({2'b00, mag_lim});
  assign sum     = 50'($signed(rdata_r)) + term;
  always_comb begin
    sum_sat = 1'b0;
    sum_cl  = sum;
    if (sum > ENT_MAX) begin
      sum_cl  = ENT_MAX;
      sum_sat = 1'b1;
    end else if (sum < ENT_MIN) begin
      sum_cl  = ENT_MIN;
      sum_sat = 1'b1;
    end
  end

  // Memory port control and result loading
  always_comb begin
    we       = 1'b0;
    waddr    = addr_r;
    wdata    = sum_cl[47:0];
    re       = 1'b0;
    raddr    = addr_r;
    load_out = 1'b0;
    load_val = '0;
    case (state_r)
      S_INIT, S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
        if (state_r == S_CLR && clr_cnt_r == tsa_pkg::ADDR_W'(tsa_pkg::STORE_DEPTH - 1)) begin
          load_out = 1'b1;
        end
      end
      S_IDLE: begin
        if (q_pop && q_data.kind == tsa_pkg::KD_READ) begin
          re    = 1'b1;
          raddr = q_data.raddr;
        end
        if (q_pop && q_data.kind == tsa_pkg::KD_RESP) begin
          load_out        = 1'b1;
          load_val.status = q_data.status;
        end
      end
      S_RDOUT: begin
        load_out             = 1'b1;
        load_val.entry_value = $signed(rdata_r);
      end
      S_PAIR: begin
        if (cx != 7'd0 && cy != 7'd0) begin
          re    = 1'b1;
          raddr = tsa_pkg::store_addr(cx - 7'd1, cy - 7'd1);
        end else if (last_pair) begin
          load_out        = 1'b1;
          load_val.status = sat_r ? tsa_pkg::ST_SAT : tsa_pkg::ST_OK;
        end
      end
      S_ACC: begin
        we = 1'b1;
        if (last_pair) begin
          load_out        = 1'b1;
          load_val.status = (sat_r | mag_sat | sum_sat) ? tsa_pkg::ST_SAT : tsa_pkg::ST_OK;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Store memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == tsa_pkg::ADDR_W'(tsa_pkg::STORE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            case (q_data.kind)
              tsa_pkg::KD_CLEAR: begin
                state_r   <= S_CLR;
                clr_cnt_r <= '0;
              end
              tsa_pkg::KD_ADD:  state_r <= S_DIV;
              tsa_pkg::KD_READ: state_r <= S_RDOUT;
              default:          state_r <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == tsa_pkg::ADDR_W'(tsa_pkg::STORE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_RDOUT: state_r <= S_IDLE;
        S_DIV: begin
          if (div_done) state_r <= S_PAIR;
        end
        S_PAIR: begin
          if (cx != 7'd0 && cy != 7'd0) state_r <= S_MUL;
          else if (last_pair) state_r <= S_IDLE;
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: state_r <= last_pair ? S_IDLE : S_PAIR;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Member datapath registers
  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= load_val;
    if (q_pop) begin
      codes_r <= q_data.codes;
      dx_r    <= q_data.dx;
      dy_r    <= q_data.dy;
      dz_r    <= q_data.dz;
      x_r     <= '0;
      y_r     <= '0;
      sat_r   <= 1'b0;
    end
    if (state_r == S_PAIR) begin
      p_r    <= prod[31] ? 31'(-prod) : prod[30:0];
      neg_r  <= prod[31] ^ ((x_r < 3'd3) != (y_r < 3'd3));
      addr_r <= raddr;
    end
    if (state_r == S_MUL) begin
      phi_r <= 63'(f_q[63:32]) * 63'(p_r);
      plo_r <= 63'(f_q[31:0]) * 63'(p_r);
    end
    if (state_r == S_ACC) sat_r <= sat_r | mag_sat | sum_sat;
    // Advance pair index after a skipped or finished pair
    if ((state_r == S_PAIR && (cx == 7'd0 || cy == 7'd0)) || state_r == S_ACC) begin
      if (y_r == 3'd5) begin
        y_r <= '0;
        if (!last_pair) x_r <= x_r + 1'b1;
      end else begin
        y_r <= y_r + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_INIT) |-> !out_valid_r)
    else $error("result produced during clearing pass");
  assert property (@(posedge clk) disable iff (!rst_n)
                   load_out |-> slot_free)
    else $error("result loaded over a waiting result");
  assert property (@(posedge clk) disable iff (!rst_n)
                   div_done |-> (state_r == S_DIV))
    else $error("divider finished outside member setup");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_ACC) |-> ($past(state_r) == S_MUL))
    else $error("accumulate without multiply step");

endmodule

// ----- bench/tb_truss_stiffness_assembly.sv -----
// Testbench for truss_stiffness_assembly: random and directed member, read and clear traffic.
// Depends on rtl/tsa_pkg.sv and the top level; predicts every result with its own store copy.
module tb_truss_stiffness_assembly;

  localparam longint ENTRY_HI = 64'sd140737488355327;
  localparam longint ENTRY_LO = -ENTRY_HI - 1;
  localparam longint TERM_CAP = 64'sd140737488355328;
  // Function code with no operation behind it
  localparam logic [1:0] FN_SPARE = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  tsa_pkg::tsa_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  tsa_pkg::tsa_out_t out_data;
  logic              cfg_wr_en;
  logic [6:0]        cfg_wr_data;

  truss_stiffness_assembly dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Own copy of the global matrix and the size register
  logic signed [47:0] model_matrix [0:tsa_pkg::STORE_DEPTH-1];
  logic [6:0]         model_dofs;

  tsa_pkg::tsa_in_t  pending_items [$];
  tsa_pkg::tsa_out_t expected_results [$];
  int       mismatches;
  int       checked;
  int       sat_seen;
  int       flagged_seen;
  int       settings_used;
  longint   cycle_no;

  // Append one item to the pending list
  function automatic void add_item(input tsa_pkg::tsa_in_t t);
    pending_items.insert(pending_items.size(), t);
  endfunction

  // Expected result of one accepted transaction; updates the model matrix
  function automatic tsa_pkg::tsa_out_t assemble_predict(input tsa_pkg::tsa_in_t t);
    tsa_pkg::tsa_out_t res;
    int unsigned   n;
    logic [6:0]    code [0:5];
    longint        dir [0:2];
    logic          bad;
    logic          sat;
    logic [63:0]   num, den, q, r, f, mag;
    logic [127:0]  wide;
    longint        prod, term, sum;
    logic          neg;
    int            idx;
    res.entry_value = '0;
    res.status = tsa_pkg::ST_OK;
    n = (model_dofs < tsa_pkg::MAX_DOF) ? model_dofs : tsa_pkg::MAX_DOF;
    case (t.func)
      tsa_pkg::FN_CLEAR: begin
        for (int k = 0; k < tsa_pkg::STORE_DEPTH; k++) model_matrix[k] = '0;
      end
      tsa_pkg::FN_ADD: begin
        bad = 1'b0;
        sat = 1'b0;
        for (int k = 0; k < 6; k++) begin
          code[k] = t.end_codes[7*k +: 7];
          if (code[k] > n) bad = 1'b1;
        end
        dir[0] = t.direction_x;
        dir[1] = t.direction_y;
        dir[2] = t.direction_z;
        if (bad) res.status = tsa_pkg::ST_RANGE;
        else if (t.member_length == 0) res.status = tsa_pkg::ST_ZERO_LEN;
        else begin
          num = 64'(t.section_area) * 64'(t.elastic_modulus);
          den = 64'd1000 * 64'(t.member_length);
          q = num / den;
          r = num % den;
          f = (q << 16) + ((r << 16) / den);
          for (int x = 0; x < 6; x++) begin
            if (code[x] == 0) continue;
            for (int y = 0; y < 6; y++) begin
              if (code[y] == 0) continue;
              prod = dir[x % 3] * dir[y % 3];
              neg = prod < 0;
              wide = 128'(f) * 128'(neg ? -prod : prod);
              mag = 64'(wide >> 28);
              if ((x < 3) != (y < 3)) neg = !neg;
              if (wide[127:28] > 100'(TERM_CAP)) begin
                mag = 64'(TERM_CAP);
                sat = 1'b1;
              end
              term = neg ? -longint'(mag) : longint'(mag);
              idx = (code[x] - 1) * tsa_pkg::MAX_DOF + (code[y] - 1);
              sum = longint'(model_matrix[idx]) + term;
              if (sum > ENTRY_HI) begin sum = ENTRY_HI; sat = 1'b1; end
              if (sum < ENTRY_LO) begin sum = ENTRY_LO; sat = 1'b1; end
              model_matrix[idx] = sum[47:0];
            end
          end
          if (sat) res.status = tsa_pkg::ST_SAT;
        end
      end
      tsa_pkg::FN_READ: begin
        if (t.read_row >= n || t.read_col >= n) res.status = tsa_pkg::ST_RANGE;
        else res.entry_value = model_matrix[t.read_row * tsa_pkg::MAX_DOF + t.read_col];
      end
      default: ;
    endcase
    if (res.status == tsa_pkg::ST_SAT) sat_seen++;
    if (res.status == tsa_pkg::ST_RANGE || res.status == tsa_pkg::ST_ZERO_LEN) flagged_seen++;
    return res;
  endfunction

  // Random member: in-range codes mostly, some fixed ends, rare bad codes and lengths
  function automatic tsa_pkg::tsa_in_t random_member(input int unsigned n);
    tsa_pkg::tsa_in_t t;
    logic    wild_code;
    logic    wide_vals;
    t = '0;
    t.func = tsa_pkg::FN_ADD;
    wild_code = ($urandom_range(0, 99) < 6) && (n < 127);
    wide_vals = $urandom_range(0, 99) < 10;
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 5) == 0 || n == 0) t.end_codes[7*k +: 7] = '0;
      else t.end_codes[7*k +: 7] = 7'($urandom_range(1, n));
    end
    if (wild_code) t.end_codes[7*$urandom_range(0, 5) +: 7] = 7'($urandom_range(n + 1, 127));
    if ($urandom_range(0, 99) < 5) t.end_codes = 42'({$urandom, $urandom});
    if ($urandom_range(0, 99) < 85) begin
      t.direction_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      t.direction_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      t.direction_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else begin
      t.direction_x = 16'($urandom);
      t.direction_y = 16'($urandom);
      t.direction_z = 16'($urandom);
    end
    if (wide_vals) begin
      t.section_area    = 24'($urandom);
      t.elastic_modulus = 24'($urandom);
      t.member_length   = 24'($urandom);
    end else begin
      t.section_area    = 24'($urandom_range(1, 65535));
      t.elastic_modulus = 24'($urandom_range(1, 16777215));
      t.member_length   = 24'($urandom_range(256, 1000000));
    end
    if ($urandom_range(0, 99) < 3) t.member_length = '0;
    t.read_row = 6'($urandom);
    t.read_col = 6'($urandom);
    return t;
  endfunction

  function automatic tsa_pkg::tsa_in_t random_read(input int unsigned n);
    tsa_pkg::tsa_in_t t;
    t = '0;
    t.func = tsa_pkg::FN_READ;
    if (n > 0 && $urandom_range(0, 99) < 85) begin
      t.read_row = 6'($urandom_range(0, (n > 64 ? 64 : n) - 1));
      t.read_col = 6'($urandom_range(0, (n > 64 ? 64 : n) - 1));
    end else begin
      t.read_row = 6'($urandom);
      t.read_col = 6'($urandom);
    end
    return t;
  endfunction

  function automatic tsa_pkg::tsa_in_t make_member(input logic signed [15:0] dx, dy, dz,
                                                   input logic [23:0] a, e, l,
                                                   input logic [41:0] codes);
    tsa_pkg::tsa_in_t t;
    t = '0;
    t.func = tsa_pkg::FN_ADD;
    t.direction_x = dx;
    t.direction_y = dy;
    t.direction_z = dz;
    t.section_area = a;
    t.elastic_modulus = e;
    t.member_length = l;
    t.end_codes = codes;
    return t;
  endfunction

  function automatic tsa_pkg::tsa_in_t make_op(input logic [1:0] fn,
                                               input logic [5:0] row, col);
    tsa_pkg::tsa_in_t t;
    t = '0;
    t.func = fn;
    t.read_row = row;
    t.read_col = col;
    return t;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Long stretch of the run with no idling on either side
  function automatic logic idle_roll();
    if (cycle_no > 30000 && cycle_no < 90000) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // Driver: feeds queued items, predicts each accepted transaction
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), assemble_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && !idle_roll()) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, field-by-field check against the oldest expectation
  always @(posedge clk) begin
    tsa_pkg::tsa_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: entry_value %0d status %0d",
                 out_data.entry_value, out_data.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.entry_value !== want.entry_value) begin
            $error("entry_value expected %0d actual %0d", want.entry_value,
                   out_data.entry_value);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            mismatches++;
          end
        end
      end
      out_stall <= idle_roll();
    end
  end

  // Wait until the block has drained, then allow its worst-case tail
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_dofs(input logic [6:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_dofs = v;
    settings_used++;
  endtask

  task automatic random_phase(input int count);
    int unsigned n;
    int roll;
    n = model_dofs;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 999);
      if (roll < 3) add_item(make_op(tsa_pkg::FN_CLEAR, '0, '0));
      else if (roll < 20) add_item(make_op(FN_SPARE, 6'($urandom), 6'($urandom)));
      else if (roll < 570) add_item(random_member(n));
      else add_item(random_read(n));
    end
  endtask

  // Stimulus and end of run
  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatches = 0;
    checked = 0;
    sat_seen = 0;
    flagged_seen = 0;
    settings_used = 0;
    cycle_no = 0;
    model_dofs = 7'd64;
    for (int k = 0; k < tsa_pkg::STORE_DEPTH; k++) model_matrix[k] = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every function, fixed ends, bad codes, zero length, saturation
    set_dofs(7'd64);
    add_item(make_op(tsa_pkg::FN_CLEAR, '0, '0));
    add_item(make_member(16'sd16384, 16'sd0, 16'sd0, 24'h100, 24'd200000, 24'h200,
                         {7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}));
    add_item(make_member(-16'sd16384, 16'sd16384, -16'sd16384, 24'hFFFFFF, 24'hFFFFFF,
                         24'd1, {7'd64, 7'd63, 7'd62, 7'd3, 7'd2, 7'd1}));
    add_item(make_member(16'sd11585, -16'sd11585, 16'sd0, 24'h1000, 24'd70000, 24'h300,
                         {7'd0, 7'd2, 7'd2, 7'd0, 7'd1, 7'd1}));
    add_item(make_member(16'sd16384, 16'sd0, 16'sd0, 24'h100, 24'd1000, 24'h100,
                         {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}));
    add_item(make_member(16'sd16384, 16'sd0, 16'sd0, 24'h100, 24'd1000, 24'h100,
                         {7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd65}));
    add_item(make_member(16'sd16384, 16'sd0, 16'sd0, 24'h100, 24'd1000, 24'h0,
                         {7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd127}));
    add_item(make_member(16'sd16384, 16'sd0, 16'sd0, 24'h100, 24'd1000, 24'h0,
                         {7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}));
    add_item(make_member(-16'sd32768, 16'sd32767, -16'sd1, 24'h0, 24'h0, 24'hFFFFFF,
                         {7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}));
    add_item(make_op(tsa_pkg::FN_READ, 6'd0, 6'd0));
    add_item(make_op(tsa_pkg::FN_READ, 6'd0, 6'd3));
    add_item(make_op(tsa_pkg::FN_READ, 6'd1, 6'd1));
    add_item(make_op(tsa_pkg::FN_READ, 6'd61, 6'd63));
    add_item(make_op(tsa_pkg::FN_READ, 6'd63, 6'd63));
    add_item(make_op(FN_SPARE, 6'd63, 6'd0));
    add_item(make_op(tsa_pkg::FN_READ, 6'd2, 6'd2));
    random_phase(280);

    // Several sizes, extremes included; entries past a shrunk size stay put
    set_dofs(7'd6);
    random_phase(260);
    set_dofs(7'd1);
    random_phase(180);
    set_dofs(7'd0);
    random_phase(80);
    set_dofs(7'd127);
    random_phase(300);
    set_dofs(7'($urandom_range(2, 63)));
    random_phase(300);
    set_dofs(7'd64);
    random_phase(300);

    drain();
    $display("checked %0d results over %0d size settings: %0d saturated, %0d flagged",
             checked, settings_used, sat_seen, flagged_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 6000000);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- truss_stiffness_assembly.f -----
rtl/tsa_pkg.sv
rtl/tsa_front.sv
rtl/tsa_queue.sv
rtl/tsa_div.sv
rtl/tsa_back.sv
rtl/truss_stiffness_assembly.sv
bench/tb_truss_stiffness_assembly.sv
